>>> rtl/pcbo_pkg.sv
// pcbo_pkg: constants, codes and box helpers for the pointer click box overlay
// depends on nothing; used by pointer_click_box_overlay
`timescale 1ns / 1ps

package pcbo_pkg;

	// ring size and box half size
	localparam int MaxClicks = 8;
	localparam int BoxHalf   = 5;

	localparam int RingW = (MaxClicks > 1) ? $clog2(MaxClicks) : 1;
	localparam int CntW  = $clog2(MaxClicks + 1);
	localparam int SumW  = CntW + 1;

	// field widths
	localparam int ActW   = 3;
	localparam int PosW   = 14;
	localparam int PlaneW = 2;
	localparam int CoordW = 12;
	localparam int SampW  = 8;
	localparam int DimW   = 13;
	localparam int LifeW  = 8;
	localparam int CfgIdxW = 2;
	localparam int CfgDatW = 13;

	// box arithmetic width, holds position plus half box and frame size
	localparam int BoxW = 16;

	// action codes
	localparam logic [ActW-1:0] ActMove     = 3'd0;
	localparam logic [ActW-1:0] ActPress    = 3'd1;
	localparam logic [ActW-1:0] ActRelease  = 3'd2;
	localparam logic [ActW-1:0] ActEndFrame = 3'd3;
	localparam logic [ActW-1:0] ActPixel    = 3'd4;

	// plane codes
	localparam logic [PlaneW-1:0] PlaneY = 2'd0;
	localparam logic [PlaneW-1:0] PlaneU = 2'd1;
	localparam logic [PlaneW-1:0] PlaneV = 2'd2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegWidth    = 2'd0;
	localparam logic [CfgIdxW-1:0] RegHeight   = 2'd1;
	localparam logic [CfgIdxW-1:0] RegLifetime = 2'd2;

	// configuration reset values
	localparam logic [DimW-1:0]  WidthReset    = 13'd640;
	localparam logic [DimW-1:0]  HeightReset   = 13'd480;
	localparam logic [LifeW-1:0] LifetimeReset = 8'd30;

	// colors
	localparam logic [SampW-1:0] CursorLuma   = 8'd0;
	localparam logic [SampW-1:0] CursorChroma = 8'd128;
	localparam logic [SampW-1:0] PressY       = 8'd150;
	localparam logic [SampW-1:0] PressU       = 8'd46;
	localparam logic [SampW-1:0] PressV       = 8'd21;
	localparam logic [SampW-1:0] ReleaseY     = 8'd76;
	localparam logic [SampW-1:0] ReleaseU     = 8'd85;
	localparam logic [SampW-1:0] ReleaseV     = 8'd255;

	// slot that sits k places after the oldest entry
	function automatic logic [RingW-1:0] ring_slot(
		input logic [RingW-1:0] oldest,
		input logic [CntW-1:0]  k
	);
		logic [SumW-1:0] sum;
		sum = SumW'(oldest) + SumW'(k);
		if (sum >= SumW'(MaxClicks)) begin
			sum = sum - SumW'(MaxClicks);
		end
		return sum[RingW-1:0];
	endfunction

	// pixel (c, r) inside the clipped box around (x, y), halved on chroma
	function automatic logic in_box(
		input logic signed [PosW-1:0] x,
		input logic signed [PosW-1:0] y,
		input logic                   chroma,
		input logic [CoordW-1:0]      c,
		input logic [CoordW-1:0]      r,
		input logic [DimW-1:0]        w,
		input logic [DimW-1:0]        h
	);
		logic signed [BoxW-1:0] xs, ys, ws, hs, cs, rs;
		logic signed [BoxW-1:0] x1, x2, y1, y2;
		logic                   in_frame;
		xs = BoxW'(x);
		ys = BoxW'(y);
		ws = $signed(BoxW'(w));
		hs = $signed(BoxW'(h));
		cs = $signed(BoxW'(c));
		rs = $signed(BoxW'(r));
		in_frame = !x[PosW-1] && !y[PosW-1] && (xs < ws) && (ys < hs);
		x1 = xs - BoxW'(BoxHalf);
		x2 = xs + BoxW'(BoxHalf);
		y1 = ys - BoxW'(BoxHalf);
		y2 = ys + BoxW'(BoxHalf);
		if (x1 < 0) x1 = '0;
		if (y1 < 0) y1 = '0;
		if (x2 > ws) x2 = ws;
		if (y2 > hs) y2 = hs;
		// chroma bounds are halved, all are non-negative when in the frame
		if (chroma) begin
			x1 = x1 >>> 1;
			x2 = x2 >>> 1;
			y1 = y1 >>> 1;
			y2 = y2 >>> 1;
		end
		return in_frame && (cs >= x1) && (cs < x2) && (rs >= y1) && (rs < y2);
	endfunction

endpackage

>>> rtl/pointer_click_box_overlay.sv
// pointer_click_box_overlay: cursor and click marker overlay on an I420 pixel stream
// depends on pcbo_pkg
`timescale 1ns / 1ps

// Usage
// One input channel (in_valid/in_ready) carries events and pixels: pointer
// move, button press, button release, end of frame and pixel. One output
// channel (out_valid/out_ready) carries sample_out, one transaction for each
// pixel and none for the other actions.
// An accepted transaction lands in an input register; from there the
// overlay test against the cursor and all ring entries runs in parallel and
// the pixel result is written to the output register. One transaction is
// taken every cycle while no pixel waits behind a held result.
// When the receiver stalls, the result waits in the output register and the
// input register still holds one more transaction; events keep flowing past
// a held pixel result, a second pixel waits in the input register.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and must be made only while the block is idle; the block does not enforce it.
// Reset hides the cursor, empties the marker ring and loads a 640x480 frame
// with a 30-frame marker lifetime; marker storage itself is not cleared.

module pointer_click_box_overlay (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_we,
	input  logic [pcbo_pkg::CfgIdxW-1:0]           cfg_index,
	input  logic [pcbo_pkg::CfgDatW-1:0]           cfg_data,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [pcbo_pkg::ActW-1:0]              action,
	input  logic signed [pcbo_pkg::PosW-1:0]       pos_x,
	input  logic signed [pcbo_pkg::PosW-1:0]       pos_y,
	input  logic [pcbo_pkg::PlaneW-1:0]            plane,
	input  logic [pcbo_pkg::CoordW-1:0]            col,
	input  logic [pcbo_pkg::CoordW-1:0]            row,
	input  logic [pcbo_pkg::SampW-1:0]             sample,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pcbo_pkg::SampW-1:0]             sample_out
);

	// configuration registers
	logic [pcbo_pkg::DimW-1:0]  frame_width_q;
	logic [pcbo_pkg::DimW-1:0]  frame_height_q;
	logic [pcbo_pkg::LifeW-1:0] click_lifetime_q;

	// input stage
	logic                                valid_s1;
	logic [pcbo_pkg::ActW-1:0]           action_s1;
	logic signed [pcbo_pkg::PosW-1:0]    pos_x_s1;
	logic signed [pcbo_pkg::PosW-1:0]    pos_y_s1;
	logic [pcbo_pkg::PlaneW-1:0]         plane_s1;
	logic [pcbo_pkg::CoordW-1:0]         col_s1;
	logic [pcbo_pkg::CoordW-1:0]         row_s1;
	logic [pcbo_pkg::SampW-1:0]          sample_s1;

	// output stage
	logic                                valid_s2;
	logic [pcbo_pkg::SampW-1:0]          sample_s2;

	// cursor and ring state
	logic signed [pcbo_pkg::PosW-1:0]    cursor_x_q;
	logic signed [pcbo_pkg::PosW-1:0]    cursor_y_q;
	logic [pcbo_pkg::RingW-1:0]          ring_oldest_q;
	logic [pcbo_pkg::CntW-1:0]           ring_count_q;
	logic signed [pcbo_pkg::PosW-1:0]    marker_x_q    [pcbo_pkg::MaxClicks];
	logic signed [pcbo_pkg::PosW-1:0]    marker_y_q    [pcbo_pkg::MaxClicks];
	logic                                marker_rel_q  [pcbo_pkg::MaxClicks];
	logic [pcbo_pkg::LifeW-1:0]          marker_left_q [pcbo_pkg::MaxClicks];

	logic fire_s1;
	logic is_pixel_s1;
	logic do_move, do_add, do_eof;

	// stage 1 advances unless a pixel meets a held result
	assign is_pixel_s1 = (action_s1 == pcbo_pkg::ActPixel);
	assign fire_s1     = valid_s1 && (!is_pixel_s1 || !valid_s2 || out_ready);
	assign in_ready    = !valid_s1 || fire_s1;
	assign out_valid   = valid_s2;
	assign sample_out  = sample_s2;

	// action decode
	always_comb begin
		do_move = 1'b0;
		do_add  = 1'b0;
		do_eof  = 1'b0;
		unique case (action_s1)
			pcbo_pkg::ActMove:                          do_move = fire_s1;
			pcbo_pkg::ActPress, pcbo_pkg::ActRelease:   do_add  = fire_s1;
			pcbo_pkg::ActEndFrame:                      do_eof  = fire_s1;
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= pcbo_pkg::WidthReset;
			frame_height_q   <= pcbo_pkg::HeightReset;
			click_lifetime_q <= pcbo_pkg::LifetimeReset;
		end else if (cfg_we) begin
			case (cfg_index)
				pcbo_pkg::RegWidth:    frame_width_q    <= cfg_data;
				pcbo_pkg::RegHeight:   frame_height_q   <= cfg_data;
				pcbo_pkg::RegLifetime: click_lifetime_q <= cfg_data[pcbo_pkg::LifeW-1:0];
				default: ;
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			pos_x_s1  <= pos_x;
			pos_y_s1  <= pos_y;
			plane_s1  <= plane;
			col_s1    <= col;
			row_s1    <= row;
			sample_s1 <= sample;
		end
	end

	// ring bookkeeping for a new marker
	logic                       ring_full;
	logic [pcbo_pkg::RingW-1:0] add_slot;
	logic [pcbo_pkg::LifeW-1:0] new_life;

	assign ring_full = (ring_count_q >= pcbo_pkg::CntW'(pcbo_pkg::MaxClicks));
	assign add_slot  = ring_full ? ring_oldest_q
		: pcbo_pkg::ring_slot(ring_oldest_q, ring_count_q);
	assign new_life  = (click_lifetime_q == '0) ? pcbo_pkg::LifeW'(1) : click_lifetime_q;

	// end of frame: count expiring entries from the oldest end
	logic [pcbo_pkg::CntW-1:0] drop_cnt;

	always_comb begin
		logic                       run;
		logic [pcbo_pkg::RingW-1:0] slot;
		drop_cnt = '0;
		run      = 1'b1;
		for (int k = 0; k < pcbo_pkg::MaxClicks; k++) begin
			slot = pcbo_pkg::ring_slot(ring_oldest_q, pcbo_pkg::CntW'(k));
			if (run && (pcbo_pkg::CntW'(k) < ring_count_q)
					&& (marker_left_q[slot] <= pcbo_pkg::LifeW'(1))) begin
				drop_cnt = drop_cnt + pcbo_pkg::CntW'(1);
			end else begin
				run = 1'b0;
			end
		end
	end

	// cursor and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q    <= '1;
			cursor_y_q    <= '1;
			ring_oldest_q <= '0;
			ring_count_q  <= '0;
		end else begin
			if (do_move) begin
				cursor_x_q <= pos_x_s1;
				cursor_y_q <= pos_y_s1;
			end
			if (do_add) begin
				if (ring_full) begin
					ring_oldest_q <= pcbo_pkg::ring_slot(ring_oldest_q, pcbo_pkg::CntW'(1));
				end else begin
					ring_count_q <= ring_count_q + pcbo_pkg::CntW'(1);
				end
			end
			if (do_eof) begin
				ring_oldest_q <= pcbo_pkg::ring_slot(ring_oldest_q, drop_cnt);
				ring_count_q  <= ring_count_q - drop_cnt;
			end
		end
	end

	// marker storage, results from entries outside the ring are never used
	always_ff @(posedge clk) begin
		if (do_add) begin
			marker_x_q[add_slot]    <= pos_x_s1;
			marker_y_q[add_slot]    <= pos_y_s1;
			marker_rel_q[add_slot]  <= (action_s1 == pcbo_pkg::ActRelease);
			marker_left_q[add_slot] <= new_life;
		end
		if (do_eof) begin
			for (int i = 0; i < pcbo_pkg::MaxClicks; i++) begin
				if (marker_left_q[i] != '0) begin
					marker_left_q[i] <= marker_left_q[i] - pcbo_pkg::LifeW'(1);
				end
			end
		end
	end

	// box tests against cursor and every slot in parallel
	logic                            chroma_s1;
	logic                            cursor_hit;
	logic [pcbo_pkg::MaxClicks-1:0]  slot_hit;

	assign chroma_s1  = (plane_s1 != pcbo_pkg::PlaneY);
	assign cursor_hit = pcbo_pkg::in_box(cursor_x_q, cursor_y_q, chroma_s1, col_s1, row_s1,
		frame_width_q, frame_height_q);

	always_comb begin
		for (int i = 0; i < pcbo_pkg::MaxClicks; i++) begin
			slot_hit[i] = (marker_left_q[i] != '0)
				&& pcbo_pkg::in_box(marker_x_q[i], marker_y_q[i], chroma_s1, col_s1, row_s1,
					frame_width_q, frame_height_q);
		end
	end

	// oldest hitting marker wins
	logic marker_found;
	logic marker_rel;

	always_comb begin
		logic [pcbo_pkg::RingW-1:0] slot;
		marker_found = 1'b0;
		marker_rel   = 1'b0;
		for (int k = 0; k < pcbo_pkg::MaxClicks; k++) begin
			slot = pcbo_pkg::ring_slot(ring_oldest_q, pcbo_pkg::CntW'(k));
			if (!marker_found && (pcbo_pkg::CntW'(k) < ring_count_q) && slot_hit[slot]) begin
				marker_found = 1'b1;
				marker_rel   = marker_rel_q[slot];
			end
		end
	end

	// result sample
	logic [pcbo_pkg::SampW-1:0] pix_out;

	always_comb begin
		pix_out = sample_s1;
		case (plane_s1)
			pcbo_pkg::PlaneY: begin
				if (cursor_hit) pix_out = pcbo_pkg::CursorLuma;
				else if (marker_found)
					pix_out = marker_rel ? pcbo_pkg::ReleaseY : pcbo_pkg::PressY;
			end
			pcbo_pkg::PlaneU: begin
				if (cursor_hit) pix_out = pcbo_pkg::CursorChroma;
				else if (marker_found)
					pix_out = marker_rel ? pcbo_pkg::ReleaseU : pcbo_pkg::PressU;
			end
			pcbo_pkg::PlaneV: begin
				if (cursor_hit) pix_out = pcbo_pkg::CursorChroma;
				else if (marker_found)
					pix_out = marker_rel ? pcbo_pkg::ReleaseV : pcbo_pkg::PressV;
			end
			default: pix_out = sample_s1;
		endcase
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && is_pixel_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire_s1 && is_pixel_s1) begin
			sample_s2 <= pix_out;
		end
	end

	// ring never holds more entries than slots
	assert property (@(posedge clk) disable iff (!arst_n)
		ring_count_q <= pcbo_pkg::CntW'(pcbo_pkg::MaxClicks))
		else $error("ring count above ring size");

	// a pixel leaving stage 1 always shows up at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && is_pixel_s1) |=> valid_s2)
		else $error("pixel result lost");

	// a held result blocks the next pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |-> !(fire_s1 && is_pixel_s1))
		else $error("held result overwritten");

	// adding to a full ring keeps it full
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_add && ring_full) |=> ring_full)
		else $error("full ring lost an entry on add");

endmodule
